// ===== design/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

  // One encoded character as it arrives.
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } in_word_t;

  // One result as it leaves.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       run_end;
    logic       stream_done;
    logic       decode_ok;
  } out_word_t;

  // Work handed from the front to the back: the bytes of one group, how many of
  // them to release, and the status that closes the string.
  typedef struct packed {
    logic [23:0] block;
    logic [1:0]  num_bytes;
    logic        is_final;
    logic        ok;
  } job_t;

  // Depth of the queue between front and back.
  localparam int JobDepth    = 4;
  localparam int JobPtrWidth = $clog2(JobDepth);
  localparam int JobCntWidth = $clog2(JobDepth + 1);

  // Character codes of the alphabet edges and the pad.
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChPad    = 8'h3d;

  // Offsets that move each range onto its six-bit value.
  localparam logic [7:0] LowerOffset = 8'd71;  // 'a' maps to 26
  localparam logic [7:0] DigitOffset = 8'd4;   // '0' maps to 52
  localparam logic [5:0] SixPlus     = 6'd62;
  localparam logic [5:0] SixSlash    = 6'd63;

  // Returns {in_alphabet, six-bit value}; the value is zero off the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] res;
    res = 7'd0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      res = {1'b1, 6'(c - ChUpperA)};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      res = {1'b1, 6'(c - LowerOffset)};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      res = {1'b1, 6'(c + DigitOffset)};
    end else if (c == ChPlus) begin
      res = {1'b1, SixPlus};
    end else if (c == ChSlash) begin
      res = {1'b1, SixSlash};
    end
    return res;
  endfunction

endpackage

// ===== design/base64_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// A character's first result passes through a queue slot, then the back-stage job register.
// Throughput: one character per cycle while the queue has room; the back stage gives one
// result word per cycle unless out_stall holds it, and a group that releases three bytes
// gives three words, absorbed by a 4-deep queue. Input stalls only while that queue is full.
// Reset: synchronous, active low; clears group state, the queue and the output stage.
module base64_stream_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::out_word_t out_word
);

  logic           job_full;
  logic           job_push;
  logic           job_pop;
  logic           job_avail;
  b64d_pkg::job_t job_in;
  b64d_pkg::job_t job_head;

  // Character classification and group tracking.
  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_in)
  );

  // Queue of pending groups.
  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .full      (job_full),
    .not_empty (job_avail),
    .head_data (job_head)
  );

  // Byte serializer and output stage.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (job_avail),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== design/b64d_front.sv =====
`timescale 1ns / 1ps

module b64d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  b64d_pkg::in_word_t in_word,
  input  logic              job_full,
  output logic              job_push,
  output b64d_pkg::job_t    job_data
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] partial_r, partial_nxt;
  logic        tip_r, tip_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic        pad;
  logic [6:0]  sx;
  logic [5:0]  six;
  logic        err_char;
  logic        err_group;
  logic        err_final;
  logic [1:0]  num_bytes;

  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;

  // Classify the character.
  assign pad = (in_word.char_code == b64d_pkg::ChPad);
  assign sx  = b64d_pkg::sextet_of(in_word.char_code);
  assign six = sx[5:0];

  always_comb begin
    // Errors from the character itself.
    err_char = err_r || (pad && !pos_r[1]) || (!pad && !sx[6]);

    // Errors that close a group: data after a pad, or padding not at the end.
    err_group = err_char;
    num_bytes = 2'd0;
    if (pos_r == 2'd3) begin
      err_group = err_char || (tip_r && !pad) || ((tip_r || pad) && !in_word.is_final);
      if (!err_group) begin
        num_bytes = 2'd1 + {1'b0, !tip_r} + {1'b0, !pad};
      end
    end

    // A string that ends mid-group is malformed.
    err_final = err_group || (pos_r != 2'd3);

    job_push           = accept && ((num_bytes != 2'd0) || in_word.is_final);
    job_data.block     = {partial_r, six};
    job_data.num_bytes = num_bytes;
    job_data.is_final  = in_word.is_final;
    job_data.ok        = !err_final;
  end

  // Group state update.
  always_comb begin
    pos_nxt     = pos_r;
    partial_nxt = partial_r;
    tip_nxt     = tip_r;
    err_nxt     = err_r;
    if (accept) begin
      if (in_word.is_final) begin
        pos_nxt     = 2'd0;
        partial_nxt = 18'd0;
        tip_nxt     = 1'b0;
        err_nxt     = 1'b0;
      end else if (pos_r == 2'd3) begin
        pos_nxt     = 2'd0;
        partial_nxt = 18'd0;
        tip_nxt     = 1'b0;
        err_nxt     = err_group;
      end else begin
        pos_nxt     = pos_r + 2'd1;
        partial_nxt = {partial_r[11:0], six};
        if (pos_r == 2'd2) begin
          tip_nxt = pad;
        end
        err_nxt = err_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 2'd0;
      partial_r <= 18'd0;
      tip_r     <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      partial_r <= partial_nxt;
      tip_r     <= tip_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
`timescale 1ns / 1ps

module b64d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output b64d_pkg::job_t head_data
);

  b64d_pkg::job_t                       slots_r [b64d_pkg::JobDepth];
  logic [b64d_pkg::JobPtrWidth-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::JobPtrWidth-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::JobCntWidth-1:0]     count_r, count_nxt;

  assign full      = (count_r == b64d_pkg::JobCntWidth'(b64d_pkg::JobDepth));
  assign not_empty = (count_r != '0);
  assign head_data = slots_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == b64d_pkg::JobPtrWidth'(b64d_pkg::JobDepth - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == b64d_pkg::JobPtrWidth'(b64d_pkg::JobDepth - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/b64d_back.sv =====
`timescale 1ns / 1ps

module b64d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  b64d_pkg::job_t     job_head,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output b64d_pkg::out_word_t out_word
);

  logic           busy_r, busy_nxt;
  b64d_pkg::job_t job_r, job_nxt;
  logic [1:0]     idx_r, idx_nxt;

  logic           last;
  logic           out_accept;
  logic [7:0]     sel_byte;

  assign out_valid  = busy_r;
  assign out_accept = busy_r && !out_stall;
  assign last       = (job_r.num_bytes == 2'd0) || (idx_r == job_r.num_bytes - 2'd1);

  // Pick the byte at the current index, most significant first.
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = job_r.block[23:16];
      2'd1:    sel_byte = job_r.block[15:8];
      default: sel_byte = job_r.block[7:0];
    endcase
  end

  always_comb begin
    out_word.has_byte    = (job_r.num_bytes != 2'd0);
    out_word.data_byte   = out_word.has_byte ? sel_byte : 8'd0;
    out_word.run_end     = last;
    out_word.stream_done = last && job_r.is_final;
    out_word.decode_ok   = last && job_r.is_final && job_r.ok;
  end

  // Take the next job when idle or once the current one has given its last word.
  always_comb begin
    job_pop  = job_avail && (!busy_r || (out_accept && last));
    busy_nxt = busy_r;
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    if (job_pop) begin
      busy_nxt = 1'b1;
      job_nxt  = job_head;
      idx_nxt  = 2'd0;
    end else if (out_accept) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

// ===== design/b64d_checker.sv =====
`timescale 1ns / 1ps

module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input b64d_pkg::out_word_t out_word
);

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // The end of a string is always the end of its character's run.
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.stream_done |-> out_word.run_end)
    else $error("stream_done without run_end");

  // A word without a byte only ever closes a string, and its data byte is zero.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.has_byte |-> out_word.stream_done && out_word.data_byte == 8'd0)
    else $error("byteless word that does not close the string");

  // Success is reported only with the end of a string.
  a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.decode_ok |-> out_word.stream_done)
    else $error("decode_ok outside stream_done");

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] char_q_t[$];

  // Hard stop for a hung run; far above the slowest legal run.
  localparam int CycleLimit  = 200000;
  localparam int RandomChars = 88;

  // Tracks the decoder's group state and holds the result words still owed.
  class decode_scoreboard;
    logic [1:0]           grp_pos;
    logic [17:0]          sextets;
    bit                   third_pad;
    bit                   malformed;
    b64d_pkg::out_word_t  awaited_words[$];
    int                   errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      grp_pos   = 2'd0;
      sextets   = 18'd0;
      third_pad = 1'b0;
      malformed = 1'b0;
    endfunction

    // Alphabet lookup; the value is zero for anything outside the alphabet.
    function void lookup(input logic [7:0] c, output bit hit, output logic [5:0] val);
      hit = 1'b1;
      val = 6'd0;
      if (c >= b64d_pkg::ChUpperA && c <= b64d_pkg::ChUpperZ) begin
        val = 6'(c - b64d_pkg::ChUpperA);
      end else if (c >= b64d_pkg::ChLowerA && c <= b64d_pkg::ChLowerZ) begin
        val = 6'(c - b64d_pkg::ChLowerA + 8'd26);
      end else if (c >= b64d_pkg::ChDigit0 && c <= b64d_pkg::ChDigit9) begin
        val = 6'(c - b64d_pkg::ChDigit0 + 8'd52);
      end else if (c == b64d_pkg::ChPlus) begin
        val = 6'd62;
      end else if (c == b64d_pkg::ChSlash) begin
        val = 6'd63;
      end else begin
        hit = 1'b0;
      end
    endfunction

    function b64d_pkg::out_word_t byte_word(logic [7:0] b, bit has);
      b64d_pkg::out_word_t w;
      w = '0;
      w.data_byte = b;
      w.has_byte  = has;
      return w;
    endfunction

    // Works out the result words that one accepted character owes.
    function void note_char(b64d_pkg::in_word_t w);
      b64d_pkg::out_word_t words[3];
      int                  n;
      bit                  hit;
      bit                  is_pad;
      logic [5:0]          six;
      logic [1:0]          pos;
      logic [23:0]         blk;
      n      = 0;
      pos    = grp_pos;
      is_pad = (w.char_code == b64d_pkg::ChPad);
      lookup(w.char_code, hit, six);
      if (is_pad) begin
        if (pos < 2'd2) malformed = 1'b1;
      end else if (!hit) begin
        malformed = 1'b1;
      end
      if (pos == 2'd2) third_pad = is_pad;

      // The fourth character closes the group and releases its bytes.
      if (pos != 2'd3) begin
        sextets = {sextets[11:0], six};
        grp_pos = pos + 2'd1;
      end else begin
        blk = {sextets, six};
        if (third_pad && !is_pad) malformed = 1'b1;
        if ((third_pad || is_pad) && !w.is_final) malformed = 1'b1;
        if (!malformed) begin
          words[n] = byte_word(blk[23:16], 1'b1);
          n++;
          if (!third_pad) begin
            words[n] = byte_word(blk[15:8], 1'b1);
            n++;
          end
          if (!is_pad) begin
            words[n] = byte_word(blk[7:0], 1'b1);
            n++;
          end
        end
        grp_pos   = 2'd0;
        sextets   = 18'd0;
        third_pad = 1'b0;
      end

      // The last character always ends with a status word.
      if (w.is_final) begin
        if (pos != 2'd3) malformed = 1'b1;
        if (n == 0) begin
          words[0] = byte_word(8'h00, 1'b0);
          n = 1;
        end
        words[n-1].stream_done = 1'b1;
        words[n-1].decode_ok   = !malformed;
        clear_string();
      end
      if (n > 0) words[n-1].run_end = 1'b1;
      for (int i = 0; i < n; i++) awaited_words = {awaited_words, words[i]};
    endfunction

    function void match(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // Compares a delivered word against the oldest one owed.
    function void check_word(b64d_pkg::out_word_t got);
      b64d_pkg::out_word_t want;
      if (awaited_words.size() == 0) begin
        $error("result word 0x%0h arrived with nothing owed", got);
        errors++;
        return;
      end
      want = awaited_words.pop_front();
      match("data_byte", want.data_byte, got.data_byte);
      match("has_byte", want.has_byte, got.has_byte);
      match("run_end", want.run_end, got.run_end);
      match("stream_done", want.stream_done, got.stream_done);
      match("decode_ok", want.decode_ok, got.decode_ok);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  b64d_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  b64d_pkg::out_word_t out_word;

  decode_scoreboard ledger = new();
  int cycle_count = 0;
  int chars_sent  = 0;
  bit calm        = 1'b0;
  bit in_gappy    = 1'b0;

  base64_stream_decoder_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  // Watch both channels; values read here are the ones before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_char(in_word);
      if (out_valid && !out_stall) ledger.check_word(out_word);
    end
  end

  // Abort a run that stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: free stretches broken by stall bursts until the quiet tail.
  initial begin
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one character word and holds it until the decoder takes it.
  task automatic send_char(logic [7:0] c, bit fin);
    if (!calm && in_gappy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_word.char_code <= c;
    in_word.is_final  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Sends a string of characters; the last one carries the final flag.
  task automatic send_seq(char_q_t txt);
    in_gappy = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_text(string s);
    char_q_t txt;
    for (int i = 0; i < s.len(); i++) txt = {txt, 8'(s[i])};
    send_seq(txt);
  endtask

  function automatic logic [7:0] symbol_char(logic [5:0] v);
    if (v < 6'd26) return 8'(b64d_pkg::ChUpperA + v);
    if (v < 6'd52) return 8'(b64d_pkg::ChLowerA + v - 8'd26);
    if (v < 6'd62) return 8'(b64d_pkg::ChDigit0 + v - 8'd52);
    return (v == 6'd62) ? b64d_pkg::ChPlus : b64d_pkg::ChSlash;
  endfunction

  // Mostly well-formed encodings with random content, some padded, a few damaged.
  task automatic send_random_string();
    char_q_t txt;
    int      groups;
    int      tail;
    int      flaw;
    int      spot;
    groups = $urandom_range(1, 4);
    for (int i = 0; i < groups * 4; i++) begin
      txt = {txt, symbol_char(6'($urandom_range(0, 63)))};
    end
    tail = $urandom_range(0, 2);
    if (tail >= 1) txt[txt.size()-1] = b64d_pkg::ChPad;
    if (tail == 2) txt[txt.size()-2] = b64d_pkg::ChPad;
    flaw = $urandom_range(0, 9);
    spot = $urandom_range(0, txt.size() - 1);
    case (flaw)
      7: begin
        txt[spot] = 8'($urandom_range(0, 255));
      end
      8: begin
        if ($urandom_range(0, 1) == 1) txt.pop_back();
        else txt = {txt, symbol_char(6'($urandom_range(0, 63)))};
      end
      9: begin
        txt[spot] = b64d_pkg::ChPad;
      end
      default: begin
      end
    endcase
    send_seq(txt);
  endtask

  initial begin
    char_q_t mixed;
    int      base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Alphabet edges, both pad lengths and each kind of malformed string.
    send_text("AZaz09+/");
    send_text("TQ==");
    send_text("TWE=");
    send_text("TQ=A");
    send_text("T");
    // Padded group that is not final, then all-ones, a second-position pad and all-zeros.
    mixed = {8'h54, 8'h51, b64d_pkg::ChPad, b64d_pkg::ChPad, 8'hff, b64d_pkg::ChPad,
             8'h00, b64d_pkg::ChUpperA};
    send_seq(mixed);
    send_text("=AAA");

    // Random strings; the tail runs with no idling on either side.
    base = chars_sent;
    while (chars_sent - base < RandomChars) begin
      if (chars_sent - base >= RandomChars - 25) calm = 1'b1;
      send_random_string();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray word time to show up.
    while (ledger.awaited_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
